// ===== hdl/cql_pkg.sv =====
// clock quality ladder package: rung state codes, ownship and utc source codes,
// register indexes and reset values. no dependencies.
`timescale 1ns / 1ps

package cql_pkg;

   localparam int unsigned CSR_INDEX_W = 3;
   localparam int unsigned CSR_DATA_W  = 32;

   localparam logic [CSR_INDEX_W-1:0] CSR_PRESENCE_MIN  = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_SILENCE_LIMIT = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_FIX_GOOD      = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_FIX_MISS      = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_PPS_MISS      = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] CSR_HOLD_CEILING  = 3'd5;
   localparam logic [CSR_INDEX_W-1:0] CSR_HOLD_GROWTH   = 3'd6;
   localparam logic [CSR_INDEX_W-1:0] CSR_DISC_UNC      = 3'd7;

   localparam logic [15:0] PRESENCE_MIN_RST  = 16'd10;
   localparam logic [7:0]  SILENCE_LIMIT_RST = 8'd50;
   localparam logic [7:0]  FIX_GOOD_RST      = 8'd3;
   localparam logic [7:0]  FIX_MISS_RST      = 8'd5;
   localparam logic [7:0]  PPS_MISS_RST      = 8'd2;
   localparam logic [31:0] HOLD_CEILING_RST  = 32'd50000;
   localparam logic [31:0] HOLD_GROWTH_RST   = 32'd2000;
   localparam logic [31:0] DISC_UNC_RST      = 32'd100;

   localparam logic [31:0] NMEA_UNC_NS = 32'd30000000;
   localparam logic [31:0] NO_UTC_UNC  = 32'hFFFF_FFFF;

   typedef enum logic [4:0] {
      RUNG_NONE = 5'b00001,
      RUNG_FREE = 5'b00010,
      RUNG_NMEA = 5'b00100,
      RUNG_HOLD = 5'b01000,
      RUNG_DISC = 5'b10000
   } rung_type;

   typedef enum logic [2:0] {
      CODE_NONE = 3'd0,
      CODE_FREE = 3'd1,
      CODE_NMEA = 3'd2,
      CODE_HOLD = 3'd3,
      CODE_DISC = 3'd4
   } rung_code_type;

   typedef enum logic [1:0] {
      OWN_NOTHING = 2'd0,
      OWN_PUSH    = 2'd1,
      OWN_CLEAR   = 2'd2
   } own_action_type;

   typedef enum logic [1:0] {
      SRC_MONO = 2'd0,
      SRC_NMEA = 2'd1,
      SRC_PPS  = 2'd2
   } utc_source_type;

   function automatic rung_code_type rung_code(input rung_type r);
      rung_code_type c;
      unique case (r)
         RUNG_NONE: c = CODE_NONE;
         RUNG_FREE: c = CODE_FREE;
         RUNG_NMEA: c = CODE_NMEA;
         RUNG_HOLD: c = CODE_HOLD;
         RUNG_DISC: c = CODE_DISC;
         default:   c = CODE_NONE;
      endcase
      return c;
   endfunction

   function automatic logic rung_has_fix(input rung_type r);
      return (r == RUNG_NMEA) || (r == RUNG_HOLD) || (r == RUNG_DISC);
   endfunction

endpackage

// ===== hdl/clock_quality_ladder_core.sv =====
// clock quality ladder: one supervisor tick in, one ladder snapshot out.
// depends on cql_pkg.
`timescale 1ns / 1ps

// Each accepted tick produces exactly one result beat: the tick lands in an input
// register, the next ladder state is formed by one pass of logic (the holdover
// add and ceiling compare is the longest path) and written together with the
// result into the output register. A new tick is
// taken every cycle while results are drained; the input register only holds when
// the output register is full and rsp_ready is low. Configuration writes are
// always taken (csr_ready is tied high) and must only happen while the block holds
// no tick. Register indexes: 0 presence_min_bytes, 1 silence_limit_ticks,
// 2 fix_good_limit, 3 fix_miss_limit, 4 pps_miss_limit, 5 holdover_ceiling_ns,
// 6 holdover_growth_ns, 7 disciplined_unc_ns.
module clock_quality_ladder_core (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic [15:0]                          req_new_bytes,
   input  logic [15:0]                          req_total_bytes,
   input  logic                                 req_fix_ok,
   input  logic [15:0]                          req_fix_number,
   input  logic                                 req_pps_seen,
   input  logic                                 req_pps_locked,
   input  logic                                 req_pps_anchor_ok,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic [2:0]                           rsp_rung,
   output logic [31:0]                          rsp_unc_ns,
   output logic [1:0]                           rsp_utc_source,
   output logic                                 rsp_has_fix,
   output logic [1:0]                           rsp_ownship_action,
   output logic                                 rsp_published,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [cql_pkg::CSR_INDEX_W-1:0]      csr_index,
   input  logic [cql_pkg::CSR_DATA_W-1:0]       csr_data
);

   // configuration
   logic [15:0] presence_min_ff;
   logic [7:0]  silence_limit_ff;
   logic [7:0]  fix_good_ff;
   logic [7:0]  fix_miss_ff;
   logic [7:0]  pps_miss_ff;
   logic [31:0] hold_ceiling_ff;
   logic [31:0] hold_growth_ff;
   logic [31:0] disc_unc_ff;

   // input stage
   logic        in_valid_ff;
   logic [15:0] in_new_bytes_ff;
   logic [15:0] in_total_bytes_ff;
   logic        in_fix_ok_ff;
   logic [15:0] in_fix_number_ff;
   logic        in_pps_seen_ff;
   logic        in_pps_locked_ff;
   logic        in_anchor_ok_ff;

   // ladder state
   cql_pkg::rung_type rung_ff, rung_in;
   logic [7:0]  silent_ff, silent_in;
   logic [7:0]  good_run_ff, good_run_in;
   logic [7:0]  miss_run_ff, miss_run_in;
   logic [15:0] last_fix_ff, last_fix_in;
   logic [7:0]  pps_run_ff, pps_run_in;
   logic [31:0] hold_unc_ff, hold_unc_in;

   // result stage
   logic                            out_valid_ff;
   cql_pkg::rung_code_type          out_rung_ff;
   logic [31:0]                     out_unc_ff, out_unc_in;
   cql_pkg::utc_source_type         out_src_ff, out_src_in;
   logic                            out_has_fix_ff;
   cql_pkg::own_action_type         out_own_ff, out_own_in;
   logic                            out_pub_ff, out_pub_in;

   logic advance;
   logic req_take;

   assign advance   = in_valid_ff && (!out_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;
   assign req_take  = req_valid && req_ready;
   assign csr_ready = 1'b1;

   // next ladder state for the tick in the input register
   always_comb begin
      logic        fresh;
      logic        fix_held;
      logic        fix_gone;
      logic        pps_gone;
      logic [31:0] hold_grown;
      cql_pkg::rung_type target;

      rung_in     = rung_ff;
      silent_in   = silent_ff;
      good_run_in = good_run_ff;
      miss_run_in = miss_run_ff;
      last_fix_in = last_fix_ff;
      pps_run_in  = pps_run_ff;
      hold_unc_in = hold_unc_ff;
      out_pub_in  = 1'b0;
      out_own_in  = cql_pkg::OWN_NOTHING;
      target      = rung_ff;
      fresh       = in_fix_ok_ff && (in_fix_number_ff != last_fix_ff);
      fix_held    = 1'b0;
      fix_gone    = 1'b0;
      pps_gone    = 1'b0;
      hold_grown  = hold_unc_ff;

      if (in_new_bytes_ff == 16'd0) begin
         if (silent_ff < silence_limit_ff) begin
            silent_in = silent_ff + 8'd1;
         end
      end else begin
         silent_in = 8'd0;
      end

      if (silent_in >= silence_limit_ff) begin
         // receiver unplugged
         good_run_in = 8'd0;
         miss_run_in = 8'd0;
         target      = cql_pkg::RUNG_NONE;
      end else if (rung_ff == cql_pkg::RUNG_NONE) begin
         if (in_total_bytes_ff >= presence_min_ff) begin
            target = cql_pkg::RUNG_FREE;
         end
      end else begin
         if (fresh) begin
            last_fix_in = in_fix_number_ff;
            if (good_run_ff < fix_good_ff) begin
               good_run_in = good_run_ff + 8'd1;
            end
            miss_run_in = 8'd0;
         end else begin
            if (miss_run_ff < fix_miss_ff) begin
               miss_run_in = miss_run_ff + 8'd1;
            end
            if (miss_run_in >= fix_miss_ff) begin
               good_run_in = 8'd0;
            end
         end
         fix_held = good_run_in >= fix_good_ff;
         fix_gone = miss_run_in >= fix_miss_ff;

         if (in_pps_seen_ff) begin
            pps_run_in = 8'd0;
         end else if (pps_run_ff < pps_miss_ff) begin
            pps_run_in = pps_run_ff + 8'd1;
         end
         pps_gone = pps_run_in >= pps_miss_ff;

         if (cql_pkg::rung_has_fix(rung_ff)) begin
            if (fix_gone) begin
               pps_run_in  = pps_miss_ff;
               hold_unc_in = 32'd0;
               target      = cql_pkg::RUNG_FREE;
            end else begin
               out_own_in = cql_pkg::OWN_PUSH;
               out_pub_in = 1'b1;
               if (rung_ff == cql_pkg::RUNG_NMEA) begin
                  if (in_pps_locked_ff) begin
                     hold_unc_in = disc_unc_ff;
                     target      = cql_pkg::RUNG_DISC;
                  end
               end else if (rung_ff == cql_pkg::RUNG_DISC) begin
                  if (pps_gone) begin
                     hold_unc_in = disc_unc_ff;
                     target      = cql_pkg::RUNG_HOLD;
                  end
               end else if (in_pps_locked_ff) begin
                  hold_unc_in = disc_unc_ff;
                  target      = cql_pkg::RUNG_DISC;
               end else begin
                  // growth stops short of wrapping
                  if (hold_unc_ff < (cql_pkg::NO_UTC_UNC - hold_growth_ff)) begin
                     hold_grown = hold_unc_ff + hold_growth_ff;
                  end
                  hold_unc_in = hold_grown;
                  if (hold_grown >= hold_ceiling_ff) begin
                     target = cql_pkg::RUNG_NMEA;
                  end
               end
            end
         end else if (fix_held) begin
            pps_run_in = 8'd0;
            target     = cql_pkg::RUNG_NMEA;
         end
      end

      // rung change publishes; crossing the fix boundary sets the ownship action
      if (target != rung_ff) begin
         out_pub_in = 1'b1;
         if (cql_pkg::rung_has_fix(target) && !cql_pkg::rung_has_fix(rung_ff)) begin
            out_own_in = cql_pkg::OWN_PUSH;
         end else if (!cql_pkg::rung_has_fix(target) && cql_pkg::rung_has_fix(rung_ff)) begin
            out_own_in = cql_pkg::OWN_CLEAR;
         end
      end
      rung_in = target;
   end

   always_comb begin
      unique case (rung_in)
         cql_pkg::RUNG_NMEA: begin
            out_unc_in = cql_pkg::NMEA_UNC_NS;
            out_src_in = cql_pkg::SRC_NMEA;
         end
         cql_pkg::RUNG_DISC: begin
            out_unc_in = disc_unc_ff;
            out_src_in = in_anchor_ok_ff ? cql_pkg::SRC_PPS : cql_pkg::SRC_NMEA;
         end
         cql_pkg::RUNG_HOLD: begin
            out_unc_in = hold_unc_in;
            out_src_in = in_anchor_ok_ff ? cql_pkg::SRC_PPS : cql_pkg::SRC_NMEA;
         end
         default: begin
            out_unc_in = cql_pkg::NO_UTC_UNC;
            out_src_in = cql_pkg::SRC_MONO;
         end
      endcase
   end

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         presence_min_ff  <= cql_pkg::PRESENCE_MIN_RST;
         silence_limit_ff <= cql_pkg::SILENCE_LIMIT_RST;
         fix_good_ff      <= cql_pkg::FIX_GOOD_RST;
         fix_miss_ff      <= cql_pkg::FIX_MISS_RST;
         pps_miss_ff      <= cql_pkg::PPS_MISS_RST;
         hold_ceiling_ff  <= cql_pkg::HOLD_CEILING_RST;
         hold_growth_ff   <= cql_pkg::HOLD_GROWTH_RST;
         disc_unc_ff      <= cql_pkg::DISC_UNC_RST;
      end else if (csr_valid) begin
         unique case (csr_index)
            cql_pkg::CSR_PRESENCE_MIN:  presence_min_ff  <= csr_data[15:0];
            cql_pkg::CSR_SILENCE_LIMIT: silence_limit_ff <= csr_data[7:0];
            cql_pkg::CSR_FIX_GOOD:      fix_good_ff      <= csr_data[7:0];
            cql_pkg::CSR_FIX_MISS:      fix_miss_ff      <= csr_data[7:0];
            cql_pkg::CSR_PPS_MISS:      pps_miss_ff      <= csr_data[7:0];
            cql_pkg::CSR_HOLD_CEILING:  hold_ceiling_ff  <= csr_data;
            cql_pkg::CSR_HOLD_GROWTH:   hold_growth_ff   <= csr_data;
            cql_pkg::CSR_DISC_UNC:      disc_unc_ff      <= csr_data;
            default: begin
            end
         endcase
      end
   end

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ready) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_new_bytes_ff   <= req_new_bytes;
         in_total_bytes_ff <= req_total_bytes;
         in_fix_ok_ff      <= req_fix_ok;
         in_fix_number_ff  <= req_fix_number;
         in_pps_seen_ff    <= req_pps_seen;
         in_pps_locked_ff  <= req_pps_locked;
         in_anchor_ok_ff   <= req_pps_anchor_ok;
      end
   end

   // ladder state
   always_ff @(posedge clock) begin
      if (reset) begin
         rung_ff     <= cql_pkg::RUNG_NONE;
         silent_ff   <= 8'd0;
         good_run_ff <= 8'd0;
         miss_run_ff <= 8'd0;
         last_fix_ff <= 16'd0;
         pps_run_ff  <= 8'd0;
         hold_unc_ff <= 32'd0;
      end else if (advance) begin
         rung_ff     <= rung_in;
         silent_ff   <= silent_in;
         good_run_ff <= good_run_in;
         miss_run_ff <= miss_run_in;
         last_fix_ff <= last_fix_in;
         pps_run_ff  <= pps_run_in;
         hold_unc_ff <= hold_unc_in;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         out_rung_ff    <= cql_pkg::rung_code(rung_in);
         out_unc_ff     <= out_unc_in;
         out_src_ff     <= out_src_in;
         out_has_fix_ff <= cql_pkg::rung_has_fix(rung_in);
         out_own_ff     <= out_own_in;
         out_pub_ff     <= out_pub_in;
      end
   end

   assign rsp_valid          = out_valid_ff;
   assign rsp_rung           = out_rung_ff;
   assign rsp_unc_ns         = out_unc_ff;
   assign rsp_utc_source     = out_src_ff;
   assign rsp_has_fix        = out_has_fix_ff;
   assign rsp_ownship_action = out_own_ff;
   assign rsp_published      = out_pub_ff;

   // an ownship action always comes with a publish
   a_own_needs_pub: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_ownship_action != cql_pkg::OWN_NOTHING) |-> rsp_published)
      else $error("ownship action without publish");

   // fix flag and source follow the reported rung
   a_fix_matches_rung: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_has_fix == (rsp_rung >= cql_pkg::CODE_NMEA)) &&
                    ((rsp_utc_source == cql_pkg::SRC_MONO) == !rsp_has_fix))
      else $error("has_fix or utc source inconsistent with rung");

   // no utc knowledge below nmea fix
   a_no_fix_unc: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_has_fix |-> rsp_unc_ns == cql_pkg::NO_UTC_UNC)
      else $error("uncertainty not all ones without fix");

   // a taken beat always lands in the input stage
   a_take_lands: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> in_valid_ff)
      else $error("accepted beat lost");

   // the ladder never leaves one-hot state and the reported rung matches it
   a_ladder_state: assert property (@(posedge clock) disable iff (reset)
      advance |=> $onehot(rung_ff) && (rsp_rung == cql_pkg::rung_code(rung_ff)))
      else $error("ladder state and reported rung disagree");

endmodule

// ===== dv/cql_checker.sv =====
// clock quality ladder checker: watches the tick, snapshot and register channels,
// predicts each snapshot beat and compares it field by field. depends on cql_pkg.
`timescale 1ns / 1ps

module cql_checker (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   input  logic                            req_ready,
   input  logic [15:0]                     req_new_bytes,
   input  logic [15:0]                     req_total_bytes,
   input  logic                            req_fix_ok,
   input  logic [15:0]                     req_fix_number,
   input  logic                            req_pps_seen,
   input  logic                            req_pps_locked,
   input  logic                            req_pps_anchor_ok,
   input  logic                            rsp_valid,
   input  logic                            rsp_ready,
   input  logic [2:0]                      rsp_rung,
   input  logic [31:0]                     rsp_unc_ns,
   input  logic [1:0]                      rsp_utc_source,
   input  logic                            rsp_has_fix,
   input  logic [1:0]                      rsp_ownship_action,
   input  logic                            rsp_published,
   input  logic                            csr_valid,
   input  logic                            csr_ready,
   input  logic [cql_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [cql_pkg::CSR_DATA_W-1:0]  csr_data,
   output int unsigned                     fail_count,
   output int unsigned                     pending
);

   typedef struct {
      logic [2:0]  rung;
      logic [31:0] unc;
      logic [1:0]  src;
      logic        has_fix;
      logic [1:0]  own;
      logic        pub;
   } ladder_snap_type;

   logic [15:0] presence_min;
   logic [7:0]  silence_limit, fix_good_lim, fix_miss_lim, pps_miss_lim;
   logic [31:0] hold_ceiling, hold_growth, disc_unc;

   cql_pkg::rung_code_type  rung_now;
   logic [7:0]              silent_run, good_run, miss_run, pps_run;
   logic [15:0]             last_fix;
   logic [31:0]             hold_unc;
   logic                    pub_now;
   cql_pkg::own_action_type own_now;

   logic            fresh, fix_held, fix_gone, pps_gone;
   ladder_snap_type snap, want;
   ladder_snap_type snap_q[$];
   int unsigned     bad_beats = 0;
   int              mism;

   initial fail_count = 0;
   initial pending = 0;

   function automatic int field_bad(input string name, input logic [31:0] exp_v,
                                    input logic [31:0] act_v);
      if (exp_v !== act_v) begin
         $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, exp_v, act_v);
         return 1;
      end
      return 0;
   endfunction

   // rung change; crossing the fix boundary pushes or clears ownship
   task automatic step_rung(input cql_pkg::rung_code_type to);
      if (to != rung_now) begin
         if (to >= cql_pkg::CODE_NMEA && rung_now < cql_pkg::CODE_NMEA)
            own_now = cql_pkg::OWN_PUSH;
         else if (to < cql_pkg::CODE_NMEA && rung_now >= cql_pkg::CODE_NMEA)
            own_now = cql_pkg::OWN_CLEAR;
         rung_now = to;
         pub_now  = 1'b1;
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         presence_min  = cql_pkg::PRESENCE_MIN_RST;
         silence_limit = cql_pkg::SILENCE_LIMIT_RST;
         fix_good_lim  = cql_pkg::FIX_GOOD_RST;
         fix_miss_lim  = cql_pkg::FIX_MISS_RST;
         pps_miss_lim  = cql_pkg::PPS_MISS_RST;
         hold_ceiling  = cql_pkg::HOLD_CEILING_RST;
         hold_growth   = cql_pkg::HOLD_GROWTH_RST;
         disc_unc      = cql_pkg::DISC_UNC_RST;
         rung_now      = cql_pkg::CODE_NONE;
         silent_run    = '0;
         good_run      = '0;
         miss_run      = '0;
         last_fix      = '0;
         pps_run       = '0;
         hold_unc      = '0;
         snap_q.delete();
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (snap_q.size() == 0) begin
               $display("%0t: snapshot beat with nothing expected, actual rung %0d", $time,
                        rsp_rung);
               bad_beats++;
            end else begin
               want = snap_q.pop_front();
               mism = 0;
               mism += field_bad("rung", want.rung, rsp_rung);
               mism += field_bad("unc_ns", want.unc, rsp_unc_ns);
               mism += field_bad("utc_source", want.src, rsp_utc_source);
               mism += field_bad("has_fix", want.has_fix, rsp_has_fix);
               mism += field_bad("ownship_action", want.own, rsp_ownship_action);
               mism += field_bad("published", want.pub, rsp_published);
               if (mism != 0) bad_beats++;
            end
         end

         if (csr_valid && csr_ready) begin
            case (csr_index)
               cql_pkg::CSR_PRESENCE_MIN:  presence_min  = csr_data[15:0];
               cql_pkg::CSR_SILENCE_LIMIT: silence_limit = csr_data[7:0];
               cql_pkg::CSR_FIX_GOOD:      fix_good_lim  = csr_data[7:0];
               cql_pkg::CSR_FIX_MISS:      fix_miss_lim  = csr_data[7:0];
               cql_pkg::CSR_PPS_MISS:      pps_miss_lim  = csr_data[7:0];
               cql_pkg::CSR_HOLD_CEILING:  hold_ceiling  = csr_data;
               cql_pkg::CSR_HOLD_GROWTH:   hold_growth   = csr_data;
               cql_pkg::CSR_DISC_UNC:      disc_unc      = csr_data;
               default: ;
            endcase
         end

         if (req_valid && req_ready) begin
            pub_now = 1'b0;
            own_now = cql_pkg::OWN_NOTHING;

            if (req_new_bytes == 16'd0) begin
               if (silent_run < silence_limit) silent_run++;
            end else begin
               silent_run = '0;
            end

            if (silent_run >= silence_limit) begin
               // receiver unplugged
               good_run = '0;
               miss_run = '0;
               step_rung(cql_pkg::CODE_NONE);
            end else if (rung_now == cql_pkg::CODE_NONE) begin
               if (req_total_bytes >= presence_min) step_rung(cql_pkg::CODE_FREE);
            end else begin
               fresh = req_fix_ok && (req_fix_number != last_fix);
               if (fresh) begin
                  last_fix = req_fix_number;
                  if (good_run < fix_good_lim) good_run++;
                  miss_run = '0;
               end else begin
                  if (miss_run < fix_miss_lim) miss_run++;
                  if (miss_run >= fix_miss_lim) good_run = '0;
               end
               fix_held = good_run >= fix_good_lim;
               fix_gone = miss_run >= fix_miss_lim;

               if (req_pps_seen) pps_run = '0;
               else if (pps_run < pps_miss_lim) pps_run++;
               pps_gone = pps_run >= pps_miss_lim;

               if (rung_now >= cql_pkg::CODE_NMEA) begin
                  if (fix_gone) begin
                     pps_run  = pps_miss_lim;
                     hold_unc = '0;
                     step_rung(cql_pkg::CODE_FREE);
                  end else begin
                     own_now = cql_pkg::OWN_PUSH;
                     pub_now = 1'b1;
                     case (rung_now)
                        cql_pkg::CODE_NMEA: begin
                           if (req_pps_locked) begin
                              hold_unc = disc_unc;
                              step_rung(cql_pkg::CODE_DISC);
                           end
                        end
                        cql_pkg::CODE_DISC: begin
                           if (pps_gone) begin
                              hold_unc = disc_unc;
                              step_rung(cql_pkg::CODE_HOLD);
                           end
                        end
                        cql_pkg::CODE_HOLD: begin
                           if (req_pps_locked) begin
                              hold_unc = disc_unc;
                              step_rung(cql_pkg::CODE_DISC);
                           end else begin
                              // growth stops short of wrapping
                              if (hold_unc < cql_pkg::NO_UTC_UNC - hold_growth)
                                 hold_unc = hold_unc + hold_growth;
                              if (hold_unc >= hold_ceiling) step_rung(cql_pkg::CODE_NMEA);
                           end
                        end
                        default: ;
                     endcase
                  end
               end else if (fix_held) begin
                  pps_run = '0;
                  step_rung(cql_pkg::CODE_NMEA);
               end
            end

            case (rung_now) inside
               cql_pkg::CODE_NMEA: begin
                  snap.unc = cql_pkg::NMEA_UNC_NS;
                  snap.src = cql_pkg::SRC_NMEA;
               end
               cql_pkg::CODE_HOLD, cql_pkg::CODE_DISC: begin
                  snap.unc = (rung_now == cql_pkg::CODE_DISC) ? disc_unc : hold_unc;
                  snap.src = req_pps_anchor_ok ? cql_pkg::SRC_PPS : cql_pkg::SRC_NMEA;
               end
               default: begin
                  snap.unc = cql_pkg::NO_UTC_UNC;
                  snap.src = cql_pkg::SRC_MONO;
               end
            endcase
            snap.rung    = rung_now;
            snap.has_fix = rung_now >= cql_pkg::CODE_NMEA;
            snap.own     = own_now;
            snap.pub     = pub_now;
            snap_q.push_back(snap);
         end
      end
      pending    <= snap_q.size();
      fail_count <= bad_beats;
   end

endmodule

// ===== dv/tb_top.sv =====
// clock quality ladder testbench top: clock, reset, tick and register stimulus,
// receiver stalls and the verdict. depends on cql_pkg, cql_checker and the core.
`timescale 1ns / 1ps

module tb_top;

   localparam int unsigned CYCLE_LIMIT = 400000;

   typedef enum int {
      TICK_HEALTHY,
      TICK_PPS_LOSS,
      TICK_FIX_LOSS,
      TICK_SILENT,
      TICK_NOISE
   } tick_mode_type;

   typedef enum int {
      RX_OPEN,
      RX_LIGHT,
      RX_HEAVY,
      RX_PULSE
   } rx_mode_type;

   logic                            clock = 1'b0;
   logic                            reset = 1'b1;
   logic                            req_valid = 1'b0;
   logic                            req_ready;
   logic [15:0]                     req_new_bytes = '0;
   logic [15:0]                     req_total_bytes = '0;
   logic                            req_fix_ok = 1'b0;
   logic [15:0]                     req_fix_number = '0;
   logic                            req_pps_seen = 1'b0;
   logic                            req_pps_locked = 1'b0;
   logic                            req_pps_anchor_ok = 1'b0;
   logic                            rsp_valid;
   logic                            rsp_ready = 1'b0;
   logic [2:0]                      rsp_rung;
   logic [31:0]                     rsp_unc_ns;
   logic [1:0]                      rsp_utc_source;
   logic                            rsp_has_fix;
   logic [1:0]                      rsp_ownship_action;
   logic                            rsp_published;
   logic                            csr_valid = 1'b0;
   logic                            csr_ready;
   logic [cql_pkg::CSR_INDEX_W-1:0] csr_index = '0;
   logic [cql_pkg::CSR_DATA_W-1:0]  csr_data = '0;

   int unsigned fail_count;
   int unsigned pending;
   int unsigned cycle_count = 0;
   logic [15:0] presence_cur = cql_pkg::PRESENCE_MIN_RST;
   logic [15:0] fix_seq = 16'd100;
   rx_mode_type rx_mode = RX_OPEN;
   int          rx_span = 0;

   clock_quality_ladder_core dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_new_bytes      (req_new_bytes),
      .req_total_bytes    (req_total_bytes),
      .req_fix_ok         (req_fix_ok),
      .req_fix_number     (req_fix_number),
      .req_pps_seen       (req_pps_seen),
      .req_pps_locked     (req_pps_locked),
      .req_pps_anchor_ok  (req_pps_anchor_ok),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_rung           (rsp_rung),
      .rsp_unc_ns         (rsp_unc_ns),
      .rsp_utc_source     (rsp_utc_source),
      .rsp_has_fix        (rsp_has_fix),
      .rsp_ownship_action (rsp_ownship_action),
      .rsp_published      (rsp_published),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_index          (csr_index),
      .csr_data           (csr_data)
   );

   cql_checker chk (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_new_bytes      (req_new_bytes),
      .req_total_bytes    (req_total_bytes),
      .req_fix_ok         (req_fix_ok),
      .req_fix_number     (req_fix_number),
      .req_pps_seen       (req_pps_seen),
      .req_pps_locked     (req_pps_locked),
      .req_pps_anchor_ok  (req_pps_anchor_ok),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_rung           (rsp_rung),
      .rsp_unc_ns         (rsp_unc_ns),
      .rsp_utc_source     (rsp_utc_source),
      .rsp_has_fix        (rsp_has_fix),
      .rsp_ownship_action (rsp_ownship_action),
      .rsp_published      (rsp_published),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_index          (csr_index),
      .csr_data           (csr_data),
      .fail_count         (fail_count),
      .pending            (pending)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("status: fail");
         $finish;
      end
   end

   // receiver stall pattern, switching to a random mode whenever its random span runs out
   always @(negedge clock) begin
      if (rx_span == 0) begin
         rx_mode <= rx_mode_type'($urandom_range(0, 3));
         rx_span <= $urandom_range(5, 60);
      end else begin
         rx_span <= rx_span - 1;
      end
      case (rx_mode)
         RX_OPEN:  rsp_ready <= 1'b1;
         RX_LIGHT: rsp_ready <= ($urandom_range(0, 3) != 0);
         RX_HEAVY: rsp_ready <= ($urandom_range(0, 3) == 0);
         default:  rsp_ready <= (rx_span[2:0] == 3'd0);
      endcase
   end

   task automatic send_tick(input logic [15:0] nb, input logic [15:0] tb, input logic fok,
                            input logic [15:0] fnum, input logic seen, input logic lck,
                            input logic anc);
      @(negedge clock);
      req_valid         <= 1'b1;
      req_new_bytes     <= nb;
      req_total_bytes   <= tb;
      req_fix_ok        <= fok;
      req_fix_number    <= fnum;
      req_pps_seen      <= seen;
      req_pps_locked    <= lck;
      req_pps_anchor_ok <= anc;
      do @(posedge clock); while (!req_ready);
   endtask

   task automatic wait_idle();
      @(negedge clock);
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
   endtask

   task automatic csr_beat(input logic [cql_pkg::CSR_INDEX_W-1:0] idx,
                           input logic [31:0] data);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      do @(posedge clock); while (!csr_ready);
   endtask

   // narrow registers get random upper bits, which the block must drop
   task automatic set_phase(input logic [15:0] pres, input logic [7:0] sil,
                            input logic [7:0] good, input logic [7:0] miss,
                            input logic [7:0] pps, input logic [31:0] ceil,
                            input logic [31:0] grow, input logic [31:0] disc);
      wait_idle();
      csr_beat(cql_pkg::CSR_PRESENCE_MIN, {16'($urandom), pres});
      csr_beat(cql_pkg::CSR_SILENCE_LIMIT, {24'($urandom), sil});
      csr_beat(cql_pkg::CSR_FIX_GOOD, {24'($urandom), good});
      csr_beat(cql_pkg::CSR_FIX_MISS, {24'($urandom), miss});
      csr_beat(cql_pkg::CSR_PPS_MISS, {24'($urandom), pps});
      csr_beat(cql_pkg::CSR_HOLD_CEILING, ceil);
      csr_beat(cql_pkg::CSR_HOLD_GROWTH, grow);
      csr_beat(cql_pkg::CSR_DISC_UNC, disc);
      @(negedge clock);
      csr_valid <= 1'b0;
      presence_cur = pres;
   endtask

   task automatic run_random(input int n_items);
      int            left, seg, burst, i, pick;
      tick_mode_type mode;
      logic [15:0]   nb, tb, fnum;
      logic          fok, seen, lck, anc;
      left  = n_items;
      burst = $urandom_range(1, 30);
      while (left > 0) begin
         pick = $urandom_range(0, 99);
         if (pick < 50) mode = TICK_HEALTHY;
         else if (pick < 65) mode = TICK_PPS_LOSS;
         else if (pick < 77) mode = TICK_FIX_LOSS;
         else if (pick < 85) mode = TICK_SILENT;
         else mode = TICK_NOISE;
         seg = (mode == TICK_SILENT) ? $urandom_range(1, 60) : $urandom_range(1, 40);
         for (i = 0; i < seg && left > 0; i++) begin
            nb   = 16'($urandom_range(1, 65535));
            tb   = 16'(32'(presence_cur) + $urandom_range(0, 65535 - int'(presence_cur)));
            anc  = $urandom_range(0, 3) != 0;
            fok  = 1'b1;
            case (mode)
               TICK_HEALTHY: begin
                  if ($urandom_range(0, 9) != 0) fix_seq = fix_seq + 16'd1;
                  else fok = 1'($urandom_range(0, 1));
                  seen = $urandom_range(0, 9) != 0;
                  lck  = $urandom_range(0, 3) != 0;
               end
               TICK_PPS_LOSS: begin
                  if ($urandom_range(0, 9) != 0) fix_seq = fix_seq + 16'd1;
                  seen = $urandom_range(0, 9) == 0;
                  lck  = $urandom_range(0, 19) == 0;
               end
               TICK_FIX_LOSS: begin
                  if ($urandom_range(0, 9) == 0) fix_seq = fix_seq + 16'd1;
                  else fok = 1'($urandom_range(0, 1));
                  seen = 1'($urandom_range(0, 1));
                  lck  = 1'($urandom_range(0, 1));
               end
               TICK_SILENT: begin
                  nb = '0;
                  tb = 16'($urandom);
                  if ($urandom_range(0, 1) != 0) fix_seq = fix_seq + 16'd1;
                  fok  = 1'($urandom_range(0, 1));
                  seen = 1'($urandom_range(0, 1));
                  lck  = 1'($urandom_range(0, 1));
               end
               default: begin
                  nb   = 16'($urandom);
                  tb   = 16'($urandom);
                  fok  = 1'($urandom_range(0, 1));
                  fix_seq = 16'($urandom);
                  seen = 1'($urandom_range(0, 1));
                  lck  = 1'($urandom_range(0, 1));
                  anc  = 1'($urandom_range(0, 1));
               end
            endcase
            fnum = fix_seq;
            send_tick(nb, tb, fok, fnum, seen, lck, anc);
            left--;
            burst--;
            if (burst == 0) begin
               if ($urandom_range(0, 3) != 0) begin
                  @(negedge clock);
                  req_valid <= 1'b0;
                  repeat ($urandom_range(0, 7)) @(negedge clock);
               end
               burst = $urandom_range(1, 30);
            end
         end
      end
   endtask

   initial begin
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed walk up and down the ladder at reset settings
      send_tick(16'hFFFF, 16'd0, 1'b0, 16'd0, 1'b0, 1'b0, 1'b0);
      send_tick(16'd1, 16'd9, 1'b0, 16'd0, 1'b0, 1'b0, 1'b0);
      send_tick(16'd1, 16'd10, 1'b0, 16'd0, 1'b0, 1'b0, 1'b0);
      send_tick(16'hFFFF, 16'hFFFF, 1'b1, 16'd0, 1'b1, 1'b1, 1'b1);
      send_tick(16'd7, 16'hFFFF, 1'b1, 16'd1, 1'b1, 1'b0, 1'b1);
      send_tick(16'd7, 16'hFFFF, 1'b1, 16'd2, 1'b1, 1'b0, 1'b1);
      send_tick(16'd7, 16'hFFFF, 1'b1, 16'hFFFF, 1'b1, 1'b0, 1'b1);
      send_tick(16'd7, 16'hFFFF, 1'b1, 16'd0, 1'b1, 1'b1, 1'b1);
      send_tick(16'd7, 16'hFFFF, 1'b1, 16'd5, 1'b0, 1'b0, 1'b0);
      send_tick(16'd7, 16'hFFFF, 1'b1, 16'd6, 1'b0, 1'b0, 1'b1);
      send_tick(16'd7, 16'hFFFF, 1'b1, 16'd7, 1'b0, 1'b0, 1'b0);
      send_tick(16'd7, 16'hFFFF, 1'b1, 16'd8, 1'b0, 1'b1, 1'b1);
      send_tick(16'd7, 16'hFFFF, 1'b0, 16'd9, 1'b1, 1'b1, 1'b1);
      send_tick(16'd7, 16'hFFFF, 1'b1, 16'd8, 1'b1, 1'b1, 1'b0);
      send_tick(16'd7, 16'hFFFF, 1'b0, 16'd10, 1'b1, 1'b1, 1'b1);
      send_tick(16'd7, 16'hFFFF, 1'b0, 16'd11, 1'b1, 1'b1, 1'b1);
      send_tick(16'd7, 16'hFFFF, 1'b0, 16'd12, 1'b1, 1'b1, 1'b1);
      send_tick(16'd0, 16'hFFFF, 1'b1, 16'd13, 1'b1, 1'b1, 1'b1);
      run_random(130);

      set_phase(16'd1, 8'd1, 8'd1, 8'd1, 8'd1, 32'd0, 32'd0, 32'd0);
      run_random(120);
      set_phase(16'hFFFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                32'hFFFF_FFFF);
      run_random(120);
      // holdover growth that would wrap past all ones
      set_phase(16'd5, 8'd20, 8'd2, 8'd6, 8'd1, 32'hFFFF_FFFF, 32'h9000_0000,
                32'h0000_1000);
      run_random(120);
      // zero limits: presence, fix gain and pps miss true at once
      set_phase(16'd0, 8'd3, 8'd0, 8'd4, 8'd0, 32'd30000, 32'd1000, 32'd50);
      run_random(80);
      set_phase(16'd10, 8'd2, 8'd1, 8'd0, 8'd3, 32'd8000, 32'd3000, 32'd700);
      run_random(60);
      // zero silence limit holds the ladder at none
      set_phase(16'd10, 8'd0, 8'd3, 8'd5, 8'd2, 32'd50000, 32'd2000, 32'd100);
      run_random(30);
      repeat (3) begin
         set_phase(16'($urandom_range(1, 200)), 8'($urandom_range(2, 30)),
                   8'($urandom_range(1, 5)), 8'($urandom_range(1, 10)),
                   8'($urandom_range(1, 5)), $urandom_range(0, 60000),
                   $urandom_range(0, 5000), $urandom_range(0, 1000));
         run_random(130);
      end

      wait_idle();
      repeat (8) @(posedge clock);
      if (fail_count == 0 && pending == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule

// ===== files.f =====
hdl/cql_pkg.sv
hdl/clock_quality_ladder_core.sv
dv/cql_checker.sv
dv/tb_top.sv
